// ===== hw/rtl/bbd_pkg.sv =====
package bbd_pkg;

   // Sizes fixed by the field and register formats.
   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int PIX_BITS = 8;
   localparam int FW_BITS = 13;
   localparam int FH_BITS = 16;
   localparam int ORD_BITS = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int SUM_BITS = 10;
   localparam int CNT_BITS = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BAYER_ORDER = 2'd2;

   // Reset values of the registers.
   localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET = 13'd640;
   localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RESET = 16'd480;
   localparam logic [ORD_BITS-1:0] BAYER_ORDER_RESET = 2'd0;

   // Color filter layouts.
   localparam logic [ORD_BITS-1:0] BAYER_GBRG = 2'd0;
   localparam logic [ORD_BITS-1:0] BAYER_GRBG = 2'd1;
   localparam logic [ORD_BITS-1:0] BAYER_BGGR = 2'd2;
   localparam logic [ORD_BITS-1:0] BAYER_RGGB = 2'd3;

   // Item kinds.
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   // Luma weights in Q0.16 and the reciprocal of three in Q0.11.
   localparam logic [15:0] LUMA_KR = 16'd13933;
   localparam logic [15:0] LUMA_KG = 16'd46871;
   localparam logic [15:0] LUMA_KB = 16'd4732;
   localparam logic [SUM_BITS-1:0] RECIP3 = 10'd683;

   typedef enum logic [1:0] {
      COL_R = 2'd0,
      COL_G = 2'd1,
      COL_B = 2'd2
   } color_type;

   typedef struct packed {
      logic                func;
      logic [PIX_BITS-1:0] raw_sample;
   } req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] red;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] blue;
      logic [PIX_BITS-1:0] luma;
      logic                frame_end;
   } rsp_type;

   typedef struct packed {
      logic [FW_BITS-1:0]  frame_width;
      logic [FH_BITS-1:0]  frame_height;
      logic [ORD_BITS-1:0] bayer_order;
   } cfg_type;

   // Neighbor masks and channel roles of one output site.
   typedef struct packed {
      logic      vu;
      logic      vd;
      logic      vl;
      logic      vr;
      color_type centre;
      color_type chan_a;
      color_type chan_b;
      logic      frame_end;
   } site_type;

   // Neighbor sums of one output pixel.
   typedef struct packed {
      logic [PIX_BITS-1:0] centre_val;
      color_type           centre;
      color_type           chan_a;
      color_type           chan_b;
      logic [SUM_BITS-1:0] sum_a;
      logic [CNT_BITS-1:0] cnt_a;
      logic [SUM_BITS-1:0] sum_b;
      logic [CNT_BITS-1:0] cnt_b;
      logic                frame_end;
   } sums_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] red;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] blue;
      logic                frame_end;
   } rgb_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] red;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] blue;
      logic [21:0]         prod_r;
      logic [23:0]         prod_g;
      logic [20:0]         prod_b;
      logic                frame_end;
   } prod_type;

   // Color of a site from the layout and the row and column parities.
   function automatic color_type site_colour(input logic [ORD_BITS-1:0] order,
                                             input logic rp, input logic cp);
      color_type c;
      case (order)
         BAYER_GBRG: c = rp ? (cp ? COL_G : COL_R) : (cp ? COL_B : COL_G);
         BAYER_GRBG: c = rp ? (cp ? COL_G : COL_B) : (cp ? COL_R : COL_G);
         BAYER_BGGR: c = rp ? (cp ? COL_R : COL_G) : (cp ? COL_G : COL_B);
         BAYER_RGGB: c = rp ? (cp ? COL_B : COL_G) : (cp ? COL_G : COL_R);
         default:    c = COL_G;
      endcase
      return c;
   endfunction

   // Blue for red and red for anything else.
   function automatic color_type opposite(input color_type c);
      return (c == COL_R) ? COL_B : COL_R;
   endfunction

endpackage

// ===== hw/rtl/bbd_ram.sv =====
module bbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write and one registered read per cycle; a read sees the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bbd_window.sv =====
module bbd_window #(
   parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  bbd_pkg::cfg_type   cfg,
   input  logic               req_valid,
   input  bbd_pkg::req_type   req_data,
   output logic               req_stall,
   output logic               out_valid,
   input  logic               out_ready,
   output bbd_pkg::sums_type  out_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = (CW + 1 > bbd_pkg::FW_BITS) ? CW + 1 : bbd_pkg::FW_BITS;
   localparam int PB = bbd_pkg::PIX_BITS;
   localparam int LW = 2 * PB;
   localparam int SB = bbd_pkg::SUM_BITS;
   localparam int NB = bbd_pkg::CNT_BITS;
   localparam int HB = bbd_pkg::FH_BITS;

   // Clearing pass over the line store after reset.
   logic          clr_active_ff;
   logic [CW-1:0] clr_addr_ff;

   // Input and output positions.
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [HB-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [HB-1:0] out_row_ff, out_row_in;

   // Stage one: the transaction waiting for its line store data.
   logic                s1_valid_ff, s1_valid_in;
   logic [CW-1:0]       s1_col_ff;
   logic [PB-1:0]       s1_sample_ff;
   logic                s1_emit_ff;
   bbd_pkg::site_type   s1_site_ff;
   logic                s1_hit_ff;
   logic [LW-1:0]       s1_fwd_ff;

   logic [PB-1:0] win_ff [9];
   logic [PB-1:0] nw [9];

   logic [EW-1:0] eff_w, fw_ext;
   logic [HB-1:0] eff_h;
   logic          accept, take, draining, emit, fire1, s1_ready;
   logic [PB-1:0] sample;
   bbd_pkg::site_type site;
   bbd_pkg::color_type hcol;

   logic          ram_wr_en;
   logic [CW-1:0] ram_wr_addr;
   logic [LW-1:0] ram_wr_data, ram_rd_data, col_data;

   logic [SB-1:0] sum_a, sum_b;
   logic [NB-1:0] cnt_a, cnt_b;

   // Effective frame size.
   always_comb begin
      fw_ext = EW'(cfg.frame_width);
      if (fw_ext < EW'(2)) begin
         eff_w = EW'(2);
      end else if (fw_ext > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = fw_ext;
      end
      eff_h = (cfg.frame_height < HB'(2)) ? HB'(2) : cfg.frame_height;
   end

   // Handshake: stage one drains into the next stage unless it gives no pixel.
   assign fire1     = s1_valid_ff && (!s1_emit_ff || out_ready);
   assign s1_ready  = !s1_valid_ff || fire1;
   assign req_stall = clr_active_ff || !s1_ready;
   assign accept    = req_valid && !req_stall;
   assign draining  = in_row_ff >= eff_h;
   assign take      = accept && (draining || req_data.func == bbd_pkg::FUNC_PIXEL);
   assign sample    = draining ? '0 : req_data.raw_sample;
   assign emit      = draining || (in_row_ff >= HB'(2)) ||
                      ((in_row_ff == HB'(1)) && (in_col_ff != '0));

   // Position counters and the site of the pixel that this transaction gives.
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      hcol = bbd_pkg::site_colour(cfg.bayer_order, out_row_ff[0], ~out_col_ff[0]);
      site.vu = out_row_ff != '0;
      site.vd = ({1'b0, out_row_ff} + (HB+1)'(1)) < {1'b0, eff_h};
      site.vl = out_col_ff != '0;
      site.vr = (EW'(out_col_ff) + EW'(1)) < eff_w;
      site.centre = bbd_pkg::site_colour(cfg.bayer_order, out_row_ff[0], out_col_ff[0]);
      if (site.centre == bbd_pkg::COL_G) begin
         site.chan_a = hcol;
         site.chan_b = bbd_pkg::opposite(hcol);
      end else begin
         site.chan_a = bbd_pkg::COL_G;
         site.chan_b = bbd_pkg::opposite(site.centre);
      end
      site.frame_end = 1'b0;
      if (take) begin
         if (!draining) begin
            if ((EW'(in_col_ff) + EW'(1)) >= eff_w) begin
               in_col_in = '0;
               in_row_in = HB'(in_row_ff + HB'(1));
            end else begin
               in_col_in = CW'(in_col_ff + CW'(1));
            end
         end
         if (emit) begin
            if (({1'b0, out_row_ff} + (HB+1)'(1)) >= {1'b0, eff_h} &&
                (EW'(out_col_ff) + EW'(1)) >= eff_w) begin
               site.frame_end = 1'b1;
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if ((EW'(out_col_ff) + EW'(1)) >= eff_w) begin
               out_col_in = '0;
               out_row_in = HB'(out_row_ff + HB'(1));
            end else begin
               out_col_in = CW'(out_col_ff + CW'(1));
            end
         end
      end
   end

   // Line store data of stage one, forwarded when the previous write hit it.
   assign col_data    = s1_hit_ff ? s1_fwd_ff : ram_rd_data;
   assign ram_wr_en   = clr_active_ff || fire1;
   assign ram_wr_addr = clr_active_ff ? clr_addr_ff : s1_col_ff;
   assign ram_wr_data = clr_active_ff ? '0 : {col_data[PB-1:0], s1_sample_ff};
   assign s1_valid_in = take ? 1'b1 : (fire1 ? 1'b0 : s1_valid_ff);

   bbd_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (take),
      .rd_addr (in_col_ff),
      .rd_data (ram_rd_data)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         if (clr_active_ff) begin
            clr_addr_ff <= CW'(clr_addr_ff + CW'(1));
            if (clr_addr_ff == CW'(MAX_WIDTH - 1)) begin
               clr_active_ff <= 1'b0;
            end
         end
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Stage one payload.
   always_ff @(posedge clock) begin
      if (take) begin
         s1_col_ff    <= in_col_ff;
         s1_sample_ff <= sample;
         s1_emit_ff   <= emit;
         s1_site_ff   <= site;
         s1_hit_ff    <= fire1 && (s1_col_ff == in_col_ff);
         s1_fwd_ff    <= ram_wr_data;
      end
   end

   // Window after the shift that this transaction causes.
   always_comb begin
      nw[0] = win_ff[1];
      nw[1] = win_ff[2];
      nw[2] = col_data[LW-1:PB];
      nw[3] = win_ff[4];
      nw[4] = win_ff[5];
      nw[5] = col_data[PB-1:0];
      nw[6] = win_ff[7];
      nw[7] = win_ff[8];
      nw[8] = s1_sample_ff;
   end

   // The window is state of the block and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (fire1) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= nw[i];
         end
      end
   end

   // Sums of the neighbors inside the frame.
   always_comb begin
      sum_a = '0;
      cnt_a = '0;
      sum_b = '0;
      cnt_b = '0;
      if (s1_site_ff.vl) begin
         sum_a = sum_a + SB'(nw[3]);
         cnt_a = cnt_a + NB'(1);
      end
      if (s1_site_ff.vr) begin
         sum_a = sum_a + SB'(nw[5]);
         cnt_a = cnt_a + NB'(1);
      end
      if (s1_site_ff.centre == bbd_pkg::COL_G) begin
         // Horizontal pair gives one color, vertical pair the other.
         if (s1_site_ff.vu) begin
            sum_b = sum_b + SB'(nw[1]);
            cnt_b = cnt_b + NB'(1);
         end
         if (s1_site_ff.vd) begin
            sum_b = sum_b + SB'(nw[7]);
            cnt_b = cnt_b + NB'(1);
         end
      end else begin
         // Cross gives green, diagonals give the opposite color.
         if (s1_site_ff.vu) begin
            sum_a = sum_a + SB'(nw[1]);
            cnt_a = cnt_a + NB'(1);
         end
         if (s1_site_ff.vd) begin
            sum_a = sum_a + SB'(nw[7]);
            cnt_a = cnt_a + NB'(1);
         end
         if (s1_site_ff.vu && s1_site_ff.vl) begin
            sum_b = sum_b + SB'(nw[0]);
            cnt_b = cnt_b + NB'(1);
         end
         if (s1_site_ff.vu && s1_site_ff.vr) begin
            sum_b = sum_b + SB'(nw[2]);
            cnt_b = cnt_b + NB'(1);
         end
         if (s1_site_ff.vd && s1_site_ff.vl) begin
            sum_b = sum_b + SB'(nw[6]);
            cnt_b = cnt_b + NB'(1);
         end
         if (s1_site_ff.vd && s1_site_ff.vr) begin
            sum_b = sum_b + SB'(nw[8]);
            cnt_b = cnt_b + NB'(1);
         end
      end
   end

   assign out_valid           = s1_valid_ff && s1_emit_ff;
   assign out_data.centre_val = nw[4];
   assign out_data.centre     = s1_site_ff.centre;
   assign out_data.chan_a     = s1_site_ff.chan_a;
   assign out_data.chan_b     = s1_site_ff.chan_b;
   assign out_data.sum_a      = sum_a;
   assign out_data.cnt_a      = cnt_a;
   assign out_data.sum_b      = sum_b;
   assign out_data.cnt_b      = cnt_b;
   assign out_data.frame_end  = s1_site_ff.frame_end;

endmodule

// ===== hw/rtl/bbd_color.sv =====
module bbd_color (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  bbd_pkg::sums_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output bbd_pkg::rgb_type  out_data
);

   localparam int PB = bbd_pkg::PIX_BITS;
   localparam int SB = bbd_pkg::SUM_BITS;
   localparam int NB = bbd_pkg::CNT_BITS;

   logic              valid_ff;
   bbd_pkg::sums_type sums_ff;
   logic [PB-1:0]     mean_a, mean_b;

   // Truncated mean of one to four samples; a third is a reciprocal multiply.
   function automatic logic [PB-1:0] mean_of(input logic [SB-1:0] s, input logic [NB-1:0] n);
      logic [2*SB:0] prod;
      logic [PB-1:0] m;
      prod = (2*SB+1)'(s) * (2*SB+1)'(bbd_pkg::RECIP3);
      case (n)
         NB'(1):  m = s[PB-1:0];
         NB'(2):  m = s[PB:1];
         NB'(3):  m = prod[PB+10:11];
         NB'(4):  m = s[PB+1:2];
         default: m = '0;
      endcase
      return m;
   endfunction

   // Value of one channel: the center sample or one of the two means.
   function automatic logic [PB-1:0] pick(input bbd_pkg::sums_type d, input logic [PB-1:0] ma,
                                          input logic [PB-1:0] mb, input bbd_pkg::color_type c);
      logic [PB-1:0] v;
      if (d.centre == c) begin
         v = d.centre_val;
      end else if (d.chan_a == c) begin
         v = ma;
      end else begin
         v = mb;
      end
      return v;
   endfunction

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sums_ff <= in_data;
      end
   end

   // Means and channel assembly.
   assign mean_a             = mean_of(sums_ff.sum_a, sums_ff.cnt_a);
   assign mean_b             = mean_of(sums_ff.sum_b, sums_ff.cnt_b);
   assign out_valid          = valid_ff;
   assign out_data.red       = pick(sums_ff, mean_a, mean_b, bbd_pkg::COL_R);
   assign out_data.green     = pick(sums_ff, mean_a, mean_b, bbd_pkg::COL_G);
   assign out_data.blue      = pick(sums_ff, mean_a, mean_b, bbd_pkg::COL_B);
   assign out_data.frame_end = sums_ff.frame_end;

endmodule

// ===== hw/rtl/bbd_luma.sv =====
module bbd_luma (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bbd_pkg::rgb_type in_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bbd_pkg::rsp_type rsp_data
);

   logic              rgb_valid_ff, prod_valid_ff, rsp_valid_ff;
   bbd_pkg::rgb_type  rgb_ff;
   bbd_pkg::prod_type prod_ff, prod_in;
   bbd_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rgb_ready, prod_ready, rsp_ready;
   logic [23:0]       luma_sum;

   // Ready chain of the three register stages.
   assign rsp_ready  = !rsp_valid_ff || !rsp_stall;
   assign prod_ready = !prod_valid_ff || rsp_ready;
   assign rgb_ready  = !rgb_valid_ff || prod_ready;
   assign in_ready   = rgb_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rgb_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rgb_ready) begin
            rgb_valid_ff <= in_valid;
         end
         if (prod_ready) begin
            prod_valid_ff <= rgb_valid_ff;
         end
         if (rsp_ready) begin
            rsp_valid_ff <= prod_valid_ff;
         end
      end
   end

   // Weighted products, one multiplier per channel.
   always_comb begin
      prod_in.red       = rgb_ff.red;
      prod_in.green     = rgb_ff.green;
      prod_in.blue      = rgb_ff.blue;
      prod_in.prod_r    = 22'(rgb_ff.red) * 22'(bbd_pkg::LUMA_KR);
      prod_in.prod_g    = 24'(rgb_ff.green) * 24'(bbd_pkg::LUMA_KG);
      prod_in.prod_b    = 21'(rgb_ff.blue) * 21'(bbd_pkg::LUMA_KB);
      prod_in.frame_end = rgb_ff.frame_end;
   end

   // Sum of products; the weights add to one, so the sum fits 24 bits.
   always_comb begin
      luma_sum           = 24'(prod_ff.prod_r) + prod_ff.prod_g + 24'(prod_ff.prod_b);
      rsp_in.red         = prod_ff.red;
      rsp_in.green       = prod_ff.green;
      rsp_in.blue        = prod_ff.blue;
      rsp_in.luma        = luma_sum[23:16];
      rsp_in.frame_end   = prod_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (rgb_ready && in_valid) begin
         rgb_ff <= in_data;
      end
      if (prod_ready && rgb_valid_ff) begin
         prod_ff <= prod_in;
      end
      if (rsp_ready && prod_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/bayer_bilinear_demosaic_top.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  bbd_pkg::req_type (func, raw_sample)
// rsp_      out        rsp_valid / rsp_stall  bbd_pkg::rsp_type (red .. frame_end)
// csr_      in         csr_wr_en              csr_index, csr_data
//
// One transaction is taken per clock while req_stall is low; a pixel leaves after the
// transaction that completes its 3x3 window has passed stage one with its line store
// read, the mean register and the luma input, product and response registers.
// After reset the line store is cleared entry by entry, with req_stall high.
// A stalled response holds the full stages in turn, and then req_stall rises.
module bayer_bilinear_demosaic_top #(
   parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bbd_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bbd_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [bbd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [bbd_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   logic [bbd_pkg::FW_BITS-1:0]  frame_width_ff;
   logic [bbd_pkg::FH_BITS-1:0]  frame_height_ff;
   logic [bbd_pkg::ORD_BITS-1:0] bayer_order_ff;
   bbd_pkg::cfg_type             cfg;

   logic              sums_valid, sums_ready;
   bbd_pkg::sums_type sums_data;
   logic              rgb_valid, rgb_ready;
   bbd_pkg::rgb_type  rgb_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bbd_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= bbd_pkg::FRAME_HEIGHT_RESET;
         bayer_order_ff  <= bbd_pkg::BAYER_ORDER_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            bbd_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[bbd_pkg::FW_BITS-1:0];
            bbd_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[bbd_pkg::FH_BITS-1:0];
            bbd_pkg::CSR_BAYER_ORDER:  bayer_order_ff  <= csr_data[bbd_pkg::ORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.frame_width  = frame_width_ff;
   assign cfg.frame_height = frame_height_ff;
   assign cfg.bayer_order  = bayer_order_ff;

   bbd_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .out_valid (sums_valid),
      .out_ready (sums_ready),
      .out_data  (sums_data)
   );

   bbd_color u_color (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sums_valid),
      .in_ready  (sums_ready),
      .in_data   (sums_data),
      .out_valid (rgb_valid),
      .out_ready (rgb_ready),
      .out_data  (rgb_data)
   );

   bbd_luma u_luma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rgb_valid),
      .in_ready  (rgb_ready),
      .in_data   (rgb_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/bbd_checker.sv =====
module bbd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bbd_pkg::rsp_type rsp_data
);

   // The line store clearing pass keeps the input closed right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> (req_stall && !(req_valid && !req_stall)))
      else $error("transaction accepted during line store clearing");

   // No response is pending right after reset.
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response stays offered.
   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // A stalled response keeps its payload.
   a_rsp_data_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

endmodule

bind bayer_bilinear_demosaic_top bbd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/bayer_bilinear_demosaic_top_tb.sv =====
`timescale 1ns / 100ps

module bayer_bilinear_demosaic_top_tb;

   localparam int LINE_MAX = 4096;
   localparam int SETTLE_CYCLES = 20;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   bbd_pkg::req_type                  req_data = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   bbd_pkg::rsp_type                  rsp_data;
   logic                              csr_wr_en = 1'b0;
   logic [bbd_pkg::CSR_IDX_BITS-1:0]  csr_index = bbd_pkg::CSR_FRAME_WIDTH;
   logic [bbd_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   bayer_bilinear_demosaic_top u_dut (.*);

   always #5 clock = ~clock;

   // Demosaic predictor state: registers, line stores, window and counters.
   logic [bbd_pkg::FW_BITS-1:0]  pr_width = bbd_pkg::FRAME_WIDTH_RESET;
   logic [bbd_pkg::FH_BITS-1:0]  pr_height = bbd_pkg::FRAME_HEIGHT_RESET;
   logic [bbd_pkg::ORD_BITS-1:0] pr_order = bbd_pkg::BAYER_ORDER_RESET;
   logic [7:0]          upper_line [LINE_MAX];
   logic [7:0]          lower_line [LINE_MAX];
   logic [7:0]          win [9];
   int unsigned         in_col, in_row, out_col, out_row;

   bbd_pkg::rsp_type pixel_queue[$];
   int      failures = 0;
   bit      quiet = 1'b0;

   // Tile colors indexed by layout, then row parity * 2 + column parity.
   const bbd_pkg::color_type tile_color [4][4] = '{
      '{bbd_pkg::COL_G, bbd_pkg::COL_B, bbd_pkg::COL_R, bbd_pkg::COL_G},
      '{bbd_pkg::COL_G, bbd_pkg::COL_R, bbd_pkg::COL_B, bbd_pkg::COL_G},
      '{bbd_pkg::COL_B, bbd_pkg::COL_G, bbd_pkg::COL_G, bbd_pkg::COL_R},
      '{bbd_pkg::COL_R, bbd_pkg::COL_G, bbd_pkg::COL_G, bbd_pkg::COL_B}};

   function automatic int unsigned eff_width();
      if (pr_width < 2) return 2;
      if (pr_width > LINE_MAX) return LINE_MAX;
      return pr_width;
   endfunction

   function automatic int unsigned eff_height();
      return (pr_height < 2) ? 2 : pr_height;
   endfunction

   function automatic int unsigned avg(int unsigned sum, int unsigned cnt);
      return (cnt == 0) ? 0 : sum / cnt;
   endfunction

   // Advances the predictor by one accepted transaction; returns 1 with a pixel.
   function automatic bit demosaic_step(input bbd_pkg::req_type req,
                                        output bbd_pkg::rsp_type px);
      int unsigned w, h, col, r, c, hs, hn, vs, vn, ds, dn;
      int unsigned chan [3];
      bit          draining, emit, vu, vd, vl, vr;
      logic [7:0]  smp;
      bbd_pkg::color_type centre, hcol;
      w = eff_width();
      h = eff_height();
      draining = in_row >= h;
      px = '0;
      if (!draining && req.func == bbd_pkg::FUNC_DRAIN) return 1'b0;
      smp = draining ? 8'd0 : req.raw_sample;
      emit = draining || in_row >= 2 || (in_row == 1 && in_col >= 1);
      col = (in_col < LINE_MAX) ? in_col : 0;
      for (int i = 0; i < 3; i++) begin
         win[i*3] = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = upper_line[col];
      win[5] = lower_line[col];
      win[8] = smp;
      upper_line[col] = lower_line[col];
      lower_line[col] = smp;
      if (!draining) begin
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      end
      if (!emit) return 1'b0;

      r = out_row;
      c = out_col;
      vu = r > 0;
      vd = r + 1 < h;
      vl = c > 0;
      vr = c + 1 < w;
      centre = tile_color[pr_order][(r % 2) * 2 + (c % 2)];
      chan[centre] = win[4];
      hs = 0; hn = 0; vs = 0; vn = 0; ds = 0; dn = 0;
      if (vl) begin hs += win[3]; hn++; end
      if (vr) begin hs += win[5]; hn++; end
      if (vu) begin vs += win[1]; vn++; end
      if (vd) begin vs += win[7]; vn++; end
      if (centre == bbd_pkg::COL_G) begin
         // Green site: horizontal pair gives one color, vertical pair the other.
         hcol = tile_color[pr_order][(r % 2) * 2 + ((c % 2) ^ 1)];
         chan[hcol] = avg(hs, hn);
         chan[(hcol == bbd_pkg::COL_R) ? bbd_pkg::COL_B : bbd_pkg::COL_R] = avg(vs, vn);
      end else begin
         // Red or blue site: cross for green, diagonals for the other color.
         if (vu && vl) begin ds += win[0]; dn++; end
         if (vu && vr) begin ds += win[2]; dn++; end
         if (vd && vl) begin ds += win[6]; dn++; end
         if (vd && vr) begin ds += win[8]; dn++; end
         chan[bbd_pkg::COL_G] = avg(hs + vs, hn + vn);
         chan[(centre == bbd_pkg::COL_R) ? bbd_pkg::COL_B : bbd_pkg::COL_R] = avg(ds, dn);
      end

      if (out_row + 1 >= h && out_col + 1 >= w) begin
         px.frame_end = 1'b1;
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      px.red = 8'(chan[bbd_pkg::COL_R]);
      px.green = 8'(chan[bbd_pkg::COL_G]);
      px.blue = 8'(chan[bbd_pkg::COL_B]);
      px.luma = 8'((13933 * chan[bbd_pkg::COL_R] + 46871 * chan[bbd_pkg::COL_G] +
                    4732 * chan[bbd_pkg::COL_B]) >> 16);
      return 1'b1;
   endfunction

   // Output side: random stall bursts, quiet near the end.
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted pixel transaction with the oldest prediction.
   always @(posedge clock) begin
      bbd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_queue.size() == 0) begin
            $error("unexpected pixel %h", rsp_data);
            failures++;
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_data.red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_data.red);
               failures++;
            end
            if (rsp_data.green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_data.green);
               failures++;
            end
            if (rsp_data.blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_data.blue);
               failures++;
            end
            if (rsp_data.luma !== want.luma) begin
               $error("luma: expected %0d, got %0d", want.luma, rsp_data.luma);
               failures++;
            end
            if (rsp_data.frame_end !== want.frame_end) begin
               $error("frame_end: expected %0d, got %0d", want.frame_end,
                      rsp_data.frame_end);
               failures++;
            end
         end
      end
   end

   // Send one transaction, with an optional idle burst first; returns its pixel.
   task automatic send_item(input bbd_pkg::req_type req, output bit has_px,
                            output bbd_pkg::rsp_type px);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (req_stall);
      has_px = demosaic_step(req, px);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bbd_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [bbd_pkg::CSR_DATA_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         bbd_pkg::CSR_FRAME_WIDTH:  pr_width = val[bbd_pkg::FW_BITS-1:0];
         bbd_pkg::CSR_FRAME_HEIGHT: pr_height = val;
         bbd_pkg::CSR_BAYER_ORDER:  pr_order = val[bbd_pkg::ORD_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic set_frame(input int w, input int h,
                            input logic [bbd_pkg::ORD_BITS-1:0] ord);
      write_reg(bbd_pkg::CSR_FRAME_WIDTH, bbd_pkg::CSR_DATA_BITS'(w));
      write_reg(bbd_pkg::CSR_FRAME_HEIGHT, bbd_pkg::CSR_DATA_BITS'(h));
      write_reg(bbd_pkg::CSR_BAYER_ORDER, bbd_pkg::CSR_DATA_BITS'(ord));
   endtask

   // Directed stimulus on a 2x2 RGGB frame.
   typedef struct packed {
      logic    func;
      logic [7:0] raw_sample;
      logic    typed;
      bbd_pkg::rsp_type want;
   } step_type;

   localparam bbd_pkg::rsp_type WHITE = '{8'hff, 8'hff, 8'hff, 8'hff, 1'b0};
   localparam bbd_pkg::rsp_type BLACK = '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0};
   localparam bbd_pkg::rsp_type BLACK_END = '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1};

   const step_type directed [] = '{
      // White frame, with a drain tick inside the frame that must be ignored.
      // The second row is flushed from the line store and goes to the predictor.
      '{bbd_pkg::FUNC_PIXEL, 8'hff, 1'b1, WHITE},
      '{bbd_pkg::FUNC_PIXEL, 8'hff, 1'b1, WHITE},
      '{bbd_pkg::FUNC_PIXEL, 8'hff, 1'b1, WHITE},
      '{bbd_pkg::FUNC_DRAIN, 8'h00, 1'b1, WHITE},
      '{bbd_pkg::FUNC_PIXEL, 8'hff, 1'b1, WHITE},
      '{bbd_pkg::FUNC_DRAIN, 8'h00, 1'b1, WHITE},
      '{bbd_pkg::FUNC_DRAIN, 8'h00, 1'b0, BLACK},
      '{bbd_pkg::FUNC_DRAIN, 8'h00, 1'b0, BLACK},
      // Surplus drain tick after the frame end.
      '{bbd_pkg::FUNC_DRAIN, 8'h55, 1'b0, BLACK},
      // Black frame; a raw sample while draining acts as a drain tick.
      '{bbd_pkg::FUNC_PIXEL, 8'h00, 1'b1, BLACK},
      '{bbd_pkg::FUNC_PIXEL, 8'h00, 1'b1, BLACK},
      '{bbd_pkg::FUNC_PIXEL, 8'h00, 1'b1, BLACK},
      '{bbd_pkg::FUNC_PIXEL, 8'h00, 1'b1, BLACK},
      '{bbd_pkg::FUNC_PIXEL, 8'hc8, 1'b1, BLACK},
      '{bbd_pkg::FUNC_DRAIN, 8'h00, 1'b1, BLACK},
      '{bbd_pkg::FUNC_DRAIN, 8'h00, 1'b1, BLACK_END},
      // Mixed frame checked by the predictor.
      '{bbd_pkg::FUNC_PIXEL, 8'h12, 1'b0, BLACK},
      '{bbd_pkg::FUNC_PIXEL, 8'hf0, 1'b0, BLACK},
      '{bbd_pkg::FUNC_PIXEL, 8'h0f, 1'b0, BLACK},
      '{bbd_pkg::FUNC_PIXEL, 8'ha5, 1'b0, BLACK},
      '{bbd_pkg::FUNC_DRAIN, 8'h00, 1'b0, BLACK},
      '{bbd_pkg::FUNC_PIXEL, 8'h7e, 1'b0, BLACK},
      '{bbd_pkg::FUNC_DRAIN, 8'h00, 1'b0, BLACK}};

   // Random phases: width, height, layout, transaction count.
   const int phase_w [6] = '{0, 3, 8191, 7, 16, 4};
   const int phase_h [6] = '{0, 3, 2, 5, 65535, 2};
   const logic [bbd_pkg::ORD_BITS-1:0] phase_ord [6] =
      '{bbd_pkg::BAYER_BGGR, bbd_pkg::BAYER_GBRG, bbd_pkg::BAYER_GRBG,
        bbd_pkg::BAYER_RGGB, bbd_pkg::BAYER_BGGR, bbd_pkg::BAYER_GBRG};
   const int phase_n [6] = '{110, 130, 60, 180, 140, 150};

   initial begin
      bbd_pkg::req_type req;
      bbd_pkg::rsp_type px;
      bit      has_px;
      for (int i = 0; i < LINE_MAX; i++) begin
         upper_line[i] = 8'd0;
         lower_line[i] = 8'd0;
      end
      foreach (win[i]) win[i] = 8'd0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_frame(2, 2, bbd_pkg::BAYER_RGGB);
      foreach (directed[i]) begin
         req.func = directed[i].func;
         req.raw_sample = directed[i].raw_sample;
         send_item(req, has_px, px);
         if (has_px) pixel_queue.push_back(directed[i].typed ? directed[i].want : px);
      end
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         set_frame(phase_w[p], phase_h[p], phase_ord[p]);
         quiet = (p == 5);
         for (int n = 0; n < phase_n[p]; n++) begin
            // Mostly well-formed frames; stray drain ticks and raw samples as noise.
            if (in_row < eff_height())
               req.func = ($urandom_range(0, 19) == 0) ? bbd_pkg::FUNC_DRAIN
                                                        : bbd_pkg::FUNC_PIXEL;
            else
               req.func = ($urandom_range(0, 3) == 0) ? bbd_pkg::FUNC_PIXEL
                                                       : bbd_pkg::FUNC_DRAIN;
            req.raw_sample = 8'($urandom_range(0, 255));
            send_item(req, has_px, px);
            if (has_px) pixel_queue.push_back(px);
            // Let the block drain completely once mid-stream.
            if (p == 3 && n == 100) begin
               req_valid <= 1'b0;
               while (pixel_queue.size() != 0) @(posedge clock);
            end
         end
         wait_idle();
      end

      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("tb: failure");
      $finish;
   end

endmodule
